// File: design/exchange_sort_records_macros.svh
// Assertion macros shared by the checkers of the record sorter.
`ifndef EXCHANGE_SORT_RECORDS_MACROS_SVH
`define EXCHANGE_SORT_RECORDS_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define EXSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that cons holds in the same cycle as ante.
`define EXSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/exsr_pkg.sv
package exsr_pkg;

    localparam int IO_KEY_W    = 16;
    localparam int TAG_W       = 6;
    localparam int BELOW_W     = 7;
    localparam int THRESH_W    = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SORT_DESCENDING = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARN_THRESHOLD  = 1'b1;

    localparam logic                DESCENDING_RESET = 1'b1;
    localparam logic [THRESH_W-1:0] THRESH_RESET     = 16'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_LOAD,
        ST_SORT_HOLD,
        ST_SORT_SCAN,
        ST_SORT_PUT,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } exsr_state_t;

    typedef struct packed {
        logic busy;
        logic emit_load;
        logic emit_last;
    } exsr_status_t;

endpackage

// File: design/exsr_store.sv
module exsr_store #(
    parameter int DEPTH = 64,
    parameter int KEY_W = 16,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [KEY_W-1:0]          wkey,
    input  logic [exsr_pkg::TAG_W-1:0] wtag,
    input  logic [AW-1:0]             raddr,
    output logic [KEY_W-1:0]          rd_key,
    output logic [exsr_pkg::TAG_W-1:0] rd_tag
);
    import exsr_pkg::*;

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [TAG_W-1:0] tag_mem [DEPTH];
    logic [KEY_W-1:0] rd_key_reg;
    logic [TAG_W-1:0] rd_tag_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            tag_mem[waddr] <= wtag;
        end
        rd_key_reg <= key_mem[raddr];
        rd_tag_reg <= tag_mem[raddr];
    end

    assign rd_key = rd_key_reg;
    assign rd_tag = rd_tag_reg;

endmodule

// File: design/exsr_cmp.sv
module exsr_cmp #(
    parameter int KEY_W = 16
) (
    input  logic [KEY_W-1:0] cand_key,
    input  logic [KEY_W-1:0] held_key,
    input  logic             descending,
    output logic             swap
);
    import exsr_pkg::*;

    // equal keys never swap
    assign swap = descending ? (cand_key > held_key) : (cand_key < held_key);

endmodule

// File: design/exsr_seq.sv
module exsr_seq #(
    parameter int KEY_W = 16,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CW-1:0]              count,
    input  logic                       descending,
    input  logic                       slot_free,
    input  logic [KEY_W-1:0]           rd_key,
    input  logic [exsr_pkg::TAG_W-1:0] rd_tag,
    output logic [AW-1:0]              raddr,
    output logic                       we,
    output logic [AW-1:0]              waddr,
    output logic [KEY_W-1:0]           wkey,
    output logic [exsr_pkg::TAG_W-1:0] wtag,
    output exsr_pkg::exsr_status_t     status
);
    import exsr_pkg::*;

    exsr_state_t      state_reg, state_next;
    logic [AW-1:0]    i_reg, i_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [KEY_W-1:0] held_key_reg, held_key_next;
    logic [TAG_W-1:0] held_tag_reg, held_tag_next;

    logic [CW-1:0] last_pos;
    logic          n_is_one;
    logic          i_end_sort;
    logic          j_end;
    logic          i_end_emit;
    logic          swap;

    assign last_pos   = CW'(count - CW'(1));
    assign n_is_one   = (count == CW'(1));
    assign i_end_sort = ((CW'(i_reg) + CW'(1)) == last_pos);
    assign j_end      = (CW'(j_reg) == last_pos);
    assign i_end_emit = (CW'(i_reg) == last_pos);

    exsr_cmp #(
        .KEY_W (KEY_W)
    ) u_cmp (
        .cand_key   (rd_key),
        .held_key   (held_key_reg),
        .descending (descending),
        .swap       (swap)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SORT_LOAD;
            end
            ST_SORT_LOAD: state_next = n_is_one ? ST_EMIT_READ : ST_SORT_HOLD;
            ST_SORT_HOLD: state_next = ST_SORT_SCAN;
            ST_SORT_SCAN:
            begin
                if (j_end)
                    state_next = ST_SORT_PUT;
            end
            ST_SORT_PUT:  state_next = i_end_sort ? ST_EMIT_READ : ST_SORT_HOLD;
            ST_EMIT_READ: state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD:
            begin
                if (slot_free)
                    state_next = i_end_emit ? ST_IDLE : ST_EMIT_READ;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        raddr            = i_reg;
        we               = 1'b0;
        waddr            = j_reg;
        wkey             = held_key_reg;
        wtag             = held_tag_reg;
        status.busy      = (state_reg != ST_IDLE);
        status.emit_load = 1'b0;
        status.emit_last = i_end_emit;
        case (state_reg)
            ST_SORT_HOLD: raddr = j_reg;
            ST_SORT_SCAN:
            begin
                raddr = AW'(j_reg + AW'(1));
                we    = swap;
            end
            ST_SORT_PUT:
            begin
                raddr = AW'(i_reg + AW'(1));
                we    = 1'b1;
                waddr = i_reg;
            end
            ST_EMIT_LOAD: status.emit_load = slot_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        i_next        = i_reg;
        j_next        = j_reg;
        held_key_next = held_key_reg;
        held_tag_next = held_tag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    i_next = '0;
            end
            ST_SORT_LOAD: j_next = AW'(i_reg + AW'(1));
            ST_SORT_HOLD:
            begin
                held_key_next = rd_key;
                held_tag_next = rd_tag;
            end
            ST_SORT_SCAN:
            begin
                if (swap)
                begin
                    held_key_next = rd_key;
                    held_tag_next = rd_tag;
                end
                if (!j_end)
                    j_next = AW'(j_reg + AW'(1));
            end
            ST_SORT_PUT:
            begin
                if (i_end_sort)
                    i_next = '0;
                else
                begin
                    i_next = AW'(i_reg + AW'(1));
                    j_next = AW'(i_reg + AW'(2));
                end
            end
            ST_EMIT_LOAD:
            begin
                if (slot_free)
                    i_next = AW'(i_reg + AW'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_key_reg <= held_key_next;
        held_tag_reg <= held_tag_next;
    end

endmodule

// File: design/exchange_sort_records.sv
// Record sorter. Words arrive on the input channel (in_valid, in_stall) as a
// key, a tag and a last marker; up to RECORDS of them are stored per set and
// further words of the set are dropped and flagged as overflow. Loading takes
// one word per cycle. A word with last_item set closes the set: the block
// raises in_stall, exchange-sorts the stored records with one shared compare
// unit against a record memory with one read and one write port, then sends
// one word per record on the output channel (out_valid, out_stall), the final
// one with out_last. The sort makes one compare and one memory read each
// cycle of its scan; each result then passes a memory read and an output
// load. Every result carries the count of keys below warn_threshold and the
// overflow flag of its set. A stalled result holds in the output register;
// sending waits for the register to free, and the next set may load while
// the final result of a set is still waiting. The configuration port writes
// the order and the threshold; write it only while idle. Reset empties the
// set, clears the output valid and sets descending order with a threshold
// of 100.
module exchange_sort_records #(
    parameter int RECORDS  = 64,
    parameter int KEY_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [exsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [exsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [exsr_pkg::IO_KEY_W-1:0]    sort_key,
    input  logic [exsr_pkg::TAG_W-1:0]       record_tag,
    input  logic                             last_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [exsr_pkg::IO_KEY_W-1:0]    out_key,
    output logic [exsr_pkg::TAG_W-1:0]       out_tag,
    output logic [exsr_pkg::BELOW_W-1:0]     below_count,
    output logic                             out_last,
    output logic                             overflow
);
    import exsr_pkg::*;

    localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CW = $clog2(RECORDS + 1);

    logic                descending_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       warn_reg, warn_next;
    logic                ovf_reg, ovf_next;

    logic                out_valid_reg, out_valid_next;
    logic [IO_KEY_W-1:0] out_key_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [BELOW_W-1:0]  below_reg;
    logic                out_last_reg;
    logic                overflow_reg;

    exsr_status_t        status;
    logic                accept;
    logic                has_room;
    logic                start;
    logic                slot_free;
    logic                set_done;
    logic [KEY_BITS-1:0] key_in;

    logic [AW-1:0]       raddr;
    logic [AW-1:0]       seq_waddr;
    logic                seq_we;
    logic [KEY_BITS-1:0] seq_wkey;
    logic [TAG_W-1:0]    seq_wtag;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_BITS-1:0] mem_wkey;
    logic [TAG_W-1:0]    mem_wtag;
    logic [KEY_BITS-1:0] rd_key;
    logic [TAG_W-1:0]    rd_tag;

    assign in_stall  = status.busy;
    assign accept    = in_valid && !in_stall;
    assign has_room  = (fill_reg < CW'(RECORDS));
    assign start     = accept && last_item;
    assign slot_free = !out_valid_reg || !out_stall;
    assign set_done  = status.emit_load && status.emit_last;
    assign key_in    = KEY_BITS'(sort_key);

    assign mem_we    = status.busy ? seq_we : (accept && has_room);
    assign mem_waddr = status.busy ? seq_waddr : fill_reg[AW-1:0];
    assign mem_wkey  = status.busy ? seq_wkey : key_in;
    assign mem_wtag  = status.busy ? seq_wtag : record_tag;

    exsr_store #(
        .DEPTH (RECORDS),
        .KEY_W (KEY_BITS),
        .AW    (AW)
    ) u_store (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wkey   (mem_wkey),
        .wtag   (mem_wtag),
        .raddr  (raddr),
        .rd_key (rd_key),
        .rd_tag (rd_tag)
    );

    exsr_seq #(
        .KEY_W (KEY_BITS),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .count      (fill_reg),
        .descending (descending_reg),
        .slot_free  (slot_free),
        .rd_key     (rd_key),
        .rd_tag     (rd_tag),
        .raddr      (raddr),
        .we         (seq_we),
        .waddr      (seq_waddr),
        .wkey       (seq_wkey),
        .wtag       (seq_wtag),
        .status     (status)
    );

    always_comb
    begin
        fill_next = fill_reg;
        warn_next = warn_reg;
        ovf_next  = ovf_reg;
        if (set_done)
        begin
            fill_next = '0;
            warn_next = '0;
            ovf_next  = 1'b0;
        end
        else if (accept)
        begin
            if (has_room)
            begin
                fill_next = CW'(fill_reg + CW'(1));
                if (key_in < threshold_reg)
                    warn_next = CW'(warn_reg + CW'(1));
            end
            else
                ovf_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.emit_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= DESCENDING_RESET;
            threshold_reg  <= THRESH_RESET;
            fill_reg       <= '0;
            warn_reg       <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SORT_DESCENDING: descending_reg <= cfg_data[0];
                    CFG_WARN_THRESHOLD:  threshold_reg  <= cfg_data[THRESH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            fill_reg      <= fill_next;
            warn_reg      <= warn_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // load the output word
    always_ff @(posedge clk)
    begin
        if (status.emit_load)
        begin
            out_key_reg  <= IO_KEY_W'(rd_key);
            out_tag_reg  <= rd_tag;
            below_reg    <= BELOW_W'(warn_reg);
            out_last_reg <= status.emit_last;
            overflow_reg <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_tag     = out_tag_reg;
    assign below_count = below_reg;
    assign out_last    = out_last_reg;
    assign overflow    = overflow_reg;

endmodule

// File: design/exsr_checker.sv
`include "exchange_sort_records_macros.svh"

module exsr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic last_item,
    input logic out_valid,
    input logic out_stall,
    input logic out_last
);
    import exsr_pkg::*;

    `EXSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "output word dropped while stalled")
    `EXSR_ASSERT_NEXT(a_last_stalls, clk, rst_n, in_valid && !in_stall && last_item, in_stall, "input not stalled after end of set")
    `EXSR_ASSERT_SAME(a_emit_busy, clk, rst_n, out_valid && !out_last, in_stall, "input taken while a set is being sent")
    `EXSR_ASSERT_SAME(a_stall_cause, clk, rst_n, $rose(in_stall), $past(in_valid && last_item), "input stall without end of set")

endmodule

bind exchange_sort_records exsr_checker u_exsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_item (last_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (out_last)
);

// File: test/record_order_checker.sv
module record_order_checker #(
    parameter int RECORDS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [exsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [exsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [exsr_pkg::IO_KEY_W-1:0]    sort_key,
    input  logic [exsr_pkg::TAG_W-1:0]       record_tag,
    input  logic                             last_item,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [exsr_pkg::IO_KEY_W-1:0]    out_key,
    input  logic [exsr_pkg::TAG_W-1:0]       out_tag,
    input  logic [exsr_pkg::BELOW_W-1:0]     below_count,
    input  logic                             out_last,
    input  logic                             overflow,
    output int                               pending,
    output int                               failures
);
    import exsr_pkg::*;

    localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;

    typedef struct packed {
        logic [IO_KEY_W-1:0] key;
        logic [TAG_W-1:0]    tag;
        logic [BELOW_W-1:0]  below;
        logic                last;
        logic                dropped;
    } sorted_word_t;

    logic [IO_KEY_W-1:0] key_mem [RECORDS];
    logic [TAG_W-1:0]    tag_mem [RECORDS];
    int                  held_count;
    int                  below_tally;
    logic                dropped_flag;
    logic                descending;
    logic [THRESH_W-1:0] threshold;
    sorted_word_t        sorted_words_q [$];

    sorted_word_t        want;
    logic [IO_KEY_W-1:0] key_swap;
    logic [TAG_W-1:0]    tag_swap;
    logic                exchange;
    int                  i;
    int                  j;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count   = 0;
            below_tally  = 0;
            dropped_flag = 1'b0;
            descending   = DESCENDING_RESET;
            threshold    = THRESH_RESET;
            sorted_words_q.delete();
            pending      = 0;
            failures     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_SORT_DESCENDING)
                    descending = cfg_data[0];
                else if (cfg_index == CFG_WARN_THRESHOLD)
                    threshold = cfg_data[THRESH_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                if (sorted_words_q.size() == 0)
                begin
                    $error("result word with no prediction: key %0d tag %0d", out_key, out_tag);
                    failures++;
                end
                else
                begin
                    want = sorted_words_q.pop_front();
                    if (out_key !== want.key)
                    begin
                        $error("out_key: expected %0d, got %0d", want.key, out_key);
                        failures++;
                    end
                    if (out_tag !== want.tag)
                    begin
                        $error("out_tag: expected %0d, got %0d", want.tag, out_tag);
                        failures++;
                    end
                    if (below_count !== want.below)
                    begin
                        $error("below_count: expected %0d, got %0d", want.below, below_count);
                        failures++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %0d, got %0d", want.last, out_last);
                        failures++;
                    end
                    if (overflow !== want.dropped)
                    begin
                        $error("overflow: expected %0d, got %0d", want.dropped, overflow);
                        failures++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (held_count < RECORDS)
                begin
                    key_mem[AW'(held_count)] = sort_key;
                    tag_mem[AW'(held_count)] = record_tag;
                    held_count++;
                    if (sort_key < threshold)
                        below_tally++;
                end
                else
                    dropped_flag = 1'b1;

                if (last_item)
                begin
                    for (i = 0; i + 1 < held_count; i++)
                    begin
                        for (j = i + 1; j < held_count; j++)
                        begin
                            exchange = descending ? (key_mem[AW'(j)] > key_mem[AW'(i)])
                                                  : (key_mem[AW'(j)] < key_mem[AW'(i)]);
                            if (exchange)
                            begin
                                key_swap         = key_mem[AW'(i)];
                                tag_swap         = tag_mem[AW'(i)];
                                key_mem[AW'(i)]  = key_mem[AW'(j)];
                                tag_mem[AW'(i)]  = tag_mem[AW'(j)];
                                key_mem[AW'(j)]  = key_swap;
                                tag_mem[AW'(j)]  = tag_swap;
                            end
                        end
                    end
                    for (i = 0; i < held_count; i++)
                    begin
                        want.key     = key_mem[AW'(i)];
                        want.tag     = tag_mem[AW'(i)];
                        want.below   = below_tally[BELOW_W-1:0];
                        want.last    = (i + 1 == held_count);
                        want.dropped = dropped_flag;
                        sorted_words_q.push_back(want);
                    end
                    held_count   = 0;
                    below_tally  = 0;
                    dropped_flag = 1'b0;
                end
            end

            pending = sorted_words_q.size();
        end
    end

endmodule

// File: test/testbench.sv
module testbench;
    import exsr_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SORT_DESCENDING;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [IO_KEY_W-1:0]    sort_key = '0;
    logic [TAG_W-1:0]       record_tag = '0;
    logic                   last_item = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [IO_KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]       out_tag;
    logic [BELOW_W-1:0]     below_count;
    logic                   out_last;
    logic                   overflow;
    int                     pending;
    int                     failures;
    logic                   calm = 1'b0;

    exchange_sort_records #(
        .RECORDS  (64),
        .KEY_BITS (16)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sort_key    (sort_key),
        .record_tag  (record_tag),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_key     (out_key),
        .out_tag     (out_tag),
        .below_count (below_count),
        .out_last    (out_last),
        .overflow    (overflow)
    );

    record_order_checker #(
        .RECORDS (64)
    ) u_order_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sort_key    (sort_key),
        .record_tag  (record_tag),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_key     (out_key),
        .out_tag     (out_tag),
        .below_count (below_count),
        .out_last    (out_last),
        .overflow    (overflow),
        .pending     (pending),
        .failures    (failures)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        if (!rst_n || calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 30);
    end

    task automatic send_word(input logic [IO_KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                             input logic last);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        sort_key   = key;
        record_tag = tag;
        last_item  = last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic logic [IO_KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else if (r < 30)
            return IO_KEY_W'($urandom_range(0, 150));
        else if (r < 50)
            return IO_KEY_W'($urandom_range(0, 7));
        else
            return IO_KEY_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'h0000;
        else if (r < 30)
            return 16'hFFFF;
        else if (r < 60)
            return CFG_DATA_W'($urandom_range(0, 200));
        else
            return CFG_DATA_W'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int set_no;
        int len;
        int n;
        int rand_items;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset order and threshold: extremes, equal keys, threshold edge
        send_word(16'd0, 6'd0, 1'b0);
        send_word(16'hFFFF, 6'd63, 1'b0);
        send_word(16'hFFFF, 6'd5, 1'b0);
        send_word(16'd100, 6'd10, 1'b0);
        send_word(16'd99, 6'd11, 1'b0);
        send_word(16'd1234, 6'd21, 1'b1);
        send_word(16'd42, 6'd33, 1'b1);

        settle();
        write_reg(CFG_SORT_DESCENDING, 16'd0);
        write_reg(CFG_WARN_THRESHOLD, 16'd0);
        send_word(16'd7, 6'd1, 1'b0);
        send_word(16'd7, 6'd2, 1'b0);
        send_word(16'd0, 6'd3, 1'b0);
        send_word(16'hFFFF, 6'd4, 1'b0);
        send_word(16'd3, 6'd5, 1'b1);

        settle();
        write_reg(CFG_WARN_THRESHOLD, 16'hFFFF);
        send_word(16'hFFFF, 6'd42, 1'b0);
        send_word(16'hFFFE, 6'd21, 1'b0);
        send_word(16'd0, 6'd63, 1'b0);
        send_word(16'hFFFF, 6'd0, 1'b1);

        settle();
        write_reg(CFG_SORT_DESCENDING, 16'd1);
        write_reg(CFG_WARN_THRESHOLD, 16'd1);
        send_word(16'd0, 6'd1, 1'b0);
        send_word(16'd1, 6'd2, 1'b0);
        send_word(16'd0, 6'd3, 1'b1);

        rand_items = 0;
        set_no = 0;
        while (rand_items < 160)
        begin
            if (set_no == 4)
                calm = 1'b1;
            if (set_no == 8)
                calm = 1'b0;
            if (set_no == 3 || $urandom_range(0, 99) < 30)
            begin
                settle();
                write_reg(CFG_SORT_DESCENDING, CFG_DATA_W'($urandom_range(0, 1)));
                write_reg(CFG_WARN_THRESHOLD, pick_threshold());
            end
            if (set_no == 2)
                len = 64;
            else if (set_no == 5)
                len = 66;
            else
                len = $urandom_range(1, 10);
            for (n = 0; n < len; n++)
                send_word(pick_key(), TAG_W'($urandom_range(0, 63)), n == len - 1);
            rand_items += len;
            set_no++;
        end

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (40) @(negedge clk);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
